// ===== rtl/core/qmn_pkg.sv =====
// constants and types for the quaternion multiply and normalize pipeline
`default_nettype none

package qmn_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int LANES     = 4;

    // exact products and their four-term sums
    localparam int PROD_W = 2 * IN_W;
    localparam int SUM_W  = PROD_W + 2;

    // rounded component, squares, squared length, length
    localparam int CW     = SUM_W + 1 - FRAC_BITS;
    localparam int SQ_W   = 2 * CW;
    localparam int S_W    = SQ_W + 2;
    localparam int ROOT_W = S_W / 2;
    localparam int RW     = ROOT_W + 3;

    // restoring divider
    localparam int DIV_W = CW + FRAC_BITS + 2;
    localparam int Q_W   = FRAC_BITS + 1;

    localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
    localparam longint POS_LIM = (ONE_VAL < 32767) ? ONE_VAL : 32767;
    localparam longint NEG_LIM = (ONE_VAL < 32768) ? ONE_VAL : 32768;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CW-1:0]     comp_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [RW-1:0]            rem_t;
    typedef logic [ROOT_W-1:0]        root_t;
    typedef logic [DIV_W-1:0]         div_t;
    typedef logic [Q_W-1:0]           quo_t;
    typedef logic signed [IN_W-1:0]   word_t;

endpackage

`default_nettype wire

// ===== rtl/core/quaternion_multiply_normalize.sv =====
// Hamilton product of two Q2.14 quaternions renormalized to unit length
//
// Fully pipelined: one transfer is accepted every cycle while the output side
// takes results. The pipeline is made of the multiply, round, square and sum
// stages, one stage per root bit of the square-root unit, one operand setup
// stage, one stage per quotient bit of the divider and the output register.
// Any stall holds the whole pipeline in place. When every rounded component
// is zero the outputs are zero and degenerate is raised.
`default_nettype none

module quaternion_multiply_normalize (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // prod_w, prod_x, prod_y, prod_z
    output logic [63:0]       m_tdata,
    // degenerate
    output logic [0:0]        m_tuser
);

    localparam int F      = qmn_pkg::FRAC_BITS;
    localparam int IN_W   = qmn_pkg::IN_W;
    localparam int LANES  = qmn_pkg::LANES;
    localparam int SUM_W  = qmn_pkg::SUM_W;
    localparam int CW     = qmn_pkg::CW;
    localparam int SQ_W   = qmn_pkg::SQ_W;
    localparam int S_W    = qmn_pkg::S_W;
    localparam int ROOT_W = qmn_pkg::ROOT_W;
    localparam int RW     = qmn_pkg::RW;
    localparam int DIV_W  = qmn_pkg::DIV_W;
    localparam int Q_W    = qmn_pkg::Q_W;

    localparam logic signed [SUM_W:0] HALF = (SUM_W+1)'(longint'(1) << (F - 1));
    localparam logic [DIV_W-1:0] POS_MAX = DIV_W'(qmn_pkg::POS_LIM);
    localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'(qmn_pkg::NEG_LIM);

    logic adv;

    logic out_v_reg;
    qmn_pkg::word_t out_reg [LANES];
    logic out_deg_reg;

    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser  = out_deg_reg;

    // multiply stage
    qmn_pkg::word_t lw [LANES];
    qmn_pkg::word_t rw [LANES];
    logic v1_reg;
    qmn_pkg::prod_t p1_reg [16];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lw[k] = s_tdata[IN_W*k +: IN_W];
            rw[k] = s_tdata[IN_W*(k+LANES) +: IN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
        if (adv) begin
            for (int a = 0; a < LANES; a++) begin
                for (int b = 0; b < LANES; b++) begin
                    p1_reg[4*a+b] <= lw[a] * rw[b];
                end
            end
        end
    end

    // sum and round stage
    function automatic logic signed [SUM_W:0] ext(input qmn_pkg::prod_t p);
        return (SUM_W+1)'(p);
    endfunction

    logic signed [SUM_W:0] rsum [LANES];
    logic v2_reg;
    qmn_pkg::comp_t c2_reg [LANES];

    always_comb begin
        rsum[0] = ext(p1_reg[0]) - ext(p1_reg[5]) - ext(p1_reg[10]) - ext(p1_reg[15]) + HALF;
        rsum[1] = ext(p1_reg[1]) + ext(p1_reg[4]) + ext(p1_reg[11]) - ext(p1_reg[14]) + HALF;
        rsum[2] = ext(p1_reg[2]) - ext(p1_reg[7]) + ext(p1_reg[8]) + ext(p1_reg[13]) + HALF;
        rsum[3] = ext(p1_reg[3]) + ext(p1_reg[6]) - ext(p1_reg[9]) + ext(p1_reg[12]) + HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            for (int k = 0; k < LANES; k++) begin
                c2_reg[k] <= rsum[k][SUM_W:F];
            end
        end
    end

    // square stage
    logic signed [SQ_W-1:0] sqr [LANES];
    logic v3_reg;
    qmn_pkg::comp_t c3_reg [LANES];
    qmn_pkg::sq_t sq3_reg [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sqr[k] = SQ_W'(c2_reg[k]) * SQ_W'(c2_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            for (int k = 0; k < LANES; k++) begin
                c3_reg[k]  <= c2_reg[k];
                sq3_reg[k] <= $unsigned(sqr[k]);
            end
        end
    end

    // squared length stage, feeds the square-root pipeline
    logic rt_v_reg [ROOT_W+1];
    logic [S_W-1:0] rt_s_reg [ROOT_W+1];
    qmn_pkg::comp_t rt_c_reg [ROOT_W+1][LANES];
    qmn_pkg::root_t rt_root_reg [ROOT_W+1];
    qmn_pkg::rem_t rt_rem_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_v_reg[0] <= 1'b0;
        end else if (adv) begin
            rt_v_reg[0] <= v3_reg;
        end
        if (adv) begin
            rt_s_reg[0] <= S_W'(sq3_reg[0]) + S_W'(sq3_reg[1])
                         + S_W'(sq3_reg[2]) + S_W'(sq3_reg[3]);
            rt_root_reg[0] <= '0;
            rt_rem_reg[0]  <= '0;
            for (int k = 0; k < LANES; k++) begin
                rt_c_reg[0][k] <= c3_reg[k];
            end
        end
    end

    // integer square root, one root bit per stage
    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        qmn_pkg::rem_t trial_rem;
        qmn_pkg::rem_t trial_sub;
        logic ge;

        assign trial_rem = {rt_rem_reg[i][RW-3:0], rt_s_reg[i][S_W-1-2*i -: 2]};
        assign trial_sub = RW'({rt_root_reg[i], 2'b01});
        assign ge        = trial_rem >= trial_sub;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                rt_v_reg[i+1] <= rt_v_reg[i];
            end
            if (adv) begin
                rt_s_reg[i+1]    <= rt_s_reg[i];
                rt_root_reg[i+1] <= {rt_root_reg[i][ROOT_W-2:0], ge};
                for (int k = 0; k < LANES; k++) begin
                    rt_c_reg[i+1][k] <= rt_c_reg[i][k];
                end
            end
        end

        if (i < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rt_rem_reg[i+1] <= ge ? trial_rem - trial_sub : trial_rem;
                end
            end
        end
    end

    // divider operand setup
    logic dv_v_reg [Q_W+1];
    logic dv_zero_reg [Q_W+1];
    logic dv_neg_reg [Q_W+1][LANES];
    qmn_pkg::quo_t dv_q_reg [Q_W+1][LANES];
    qmn_pkg::div_t dv_rem_reg [Q_W][LANES];
    qmn_pkg::div_t dv_d_reg [Q_W];

    qmn_pkg::comp_t cfin [LANES];
    qmn_pkg::comp_t cmag [LANES];
    qmn_pkg::root_t mlen;

    always_comb begin
        mlen = rt_root_reg[ROOT_W];
        for (int k = 0; k < LANES; k++) begin
            cfin[k] = rt_c_reg[ROOT_W][k];
            cmag[k] = cfin[k][CW-1] ? -cfin[k] : cfin[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= rt_v_reg[ROOT_W];
        end
        if (adv) begin
            dv_zero_reg[0] <= rt_s_reg[ROOT_W] == '0;
            dv_d_reg[0]    <= DIV_W'(mlen) << 1;
            for (int k = 0; k < LANES; k++) begin
                dv_neg_reg[0][k] <= cfin[k][CW-1];
                dv_q_reg[0][k]   <= '0;
                dv_rem_reg[0][k] <= (DIV_W'($unsigned(cmag[k])) << (F + 1)) + DIV_W'(mlen);
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = F - j;
        qmn_pkg::div_t sub;
        logic ge [LANES];

        assign sub = dv_d_reg[j] << B;

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                ge[k] = dv_rem_reg[j][k] >= sub;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            if (adv) begin
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                for (int k = 0; k < LANES; k++) begin
                    dv_neg_reg[j+1][k] <= dv_neg_reg[j][k];
                    dv_q_reg[j+1][k]   <= dv_q_reg[j][k] | (Q_W'(ge[k]) << B);
                end
            end
        end

        if (j < Q_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_d_reg[j+1] <= dv_d_reg[j];
                    for (int k = 0; k < LANES; k++) begin
                        dv_rem_reg[j+1][k] <= ge[k] ? dv_rem_reg[j][k] - sub
                                                    : dv_rem_reg[j][k];
                    end
                end
            end
        end
    end

    // sign, saturation and output register
    qmn_pkg::div_t qe [LANES];
    qmn_pkg::div_t res [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            qe[k] = DIV_W'(dv_q_reg[Q_W][k]);
            if (dv_zero_reg[Q_W]) begin
                res[k] = '0;
            end else if (dv_neg_reg[Q_W][k]) begin
                res[k] = -((qe[k] > NEG_MAX) ? NEG_MAX : qe[k]);
            end else begin
                res[k] = (qe[k] > POS_MAX) ? POS_MAX : qe[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv_v_reg[Q_W];
        end
        if (adv) begin
            out_deg_reg <= dv_zero_reg[Q_W];
            for (int k = 0; k < LANES; k++) begin
                out_reg[k] <= res[k][IN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_product_checker.sv =====
// checker for the quaternion multiply and normalize block: predicts and compares each result
`timescale 1ns / 100ps
`default_nettype none

module quaternion_product_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                fail_count,
    output int                pending_count,
    output int                result_count,
    output int                degenerate_count
);

    typedef struct packed {
        logic [0:0]  degenerate;
        logic [63:0] prod;
    } unit_product_t;

    unit_product_t expected_products[$];

    function automatic longint sign16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint floor_div_pow2(longint v);
        return v >>> qmn_pkg::FRAC_BITS;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = longint'($floor($sqrt(real'(n))));
        while (r * r > n) r--;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint hi;
        longint lo;
        hi = qmn_pkg::ONE_VAL < 32767 ? qmn_pkg::ONE_VAL : 32767;
        lo = qmn_pkg::ONE_VAL < 32768 ? -qmn_pkg::ONE_VAL : -32768;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic unit_product_t normalized_product(logic [127:0] d);
        longint lw, lx, ly, lz, rw, rx, ry, rz;
        longint sums[4];
        longint comp[4];
        longint sq;
        longint len;
        longint n, an, q, v;
        unit_product_t res;
        lw = sign16(d[15:0]);    lx = sign16(d[31:16]);
        ly = sign16(d[47:32]);   lz = sign16(d[63:48]);
        rw = sign16(d[79:64]);   rx = sign16(d[95:80]);
        ry = sign16(d[111:96]);  rz = sign16(d[127:112]);
        sums[0] = lw*rw - lx*rx - ly*ry - lz*rz;
        sums[1] = lw*rx + lx*rw + ly*rz - lz*ry;
        sums[2] = lw*ry - lx*rz + ly*rw + lz*rx;
        sums[3] = lw*rz + lx*ry - ly*rx + lz*rw;
        sq = 0;
        for (int i = 0; i < 4; i++) begin
            comp[i] = floor_div_pow2(sums[i] + (longint'(1) << (qmn_pkg::FRAC_BITS - 1)));
            sq += comp[i] * comp[i];
        end
        res = '0;
        if (sq == 0) begin
            for (int i = 0; i < 4; i++) res.prod[16*i +: 16] = 16'(clamp_unit(comp[i]));
            res.degenerate = 1'b1;
        end else begin
            len = root_floor(sq);
            for (int i = 0; i < 4; i++) begin
                n = comp[i] * (longint'(1) << qmn_pkg::FRAC_BITS);
                an = n < 0 ? -n : n;
                q = (an * 2 + len) / (len * 2);
                v = n < 0 ? -q : q;
                res.prod[16*i +: 16] = 16'(clamp_unit(v));
            end
        end
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        degenerate_count = 0;
    end

    always @(posedge aclk) begin
        unit_product_t want;
        int errs;
        errs = 0;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_products.push_back(normalized_product(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (m_tuser[0]) degenerate_count <= degenerate_count + 1;
                if (expected_products.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
                    errs = 1;
                end else begin
                    want = expected_products.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (want.prod[16*i +: 16] !== m_tdata[16*i +: 16]) begin
                            $display("%0t: component %0d expected %h actual %h", $time, i,
                                     want.prod[16*i +: 16], m_tdata[16*i +: 16]);
                            errs++;
                        end
                    if (want.degenerate !== m_tuser) begin
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 want.degenerate, m_tuser);
                        errs++;
                    end
                end
            end
        end
        if (errs != 0) fail_count <= fail_count + errs;
        pending_count <= expected_products.size();
    end
endmodule

`default_nettype wire

// ===== tb/sv/quaternion_multiply_normalize_test.sv =====
// stimulus and verdict for the quaternion multiply and normalize block
`timescale 1ns / 100ps
`default_nettype none

module quaternion_multiply_normalize_test;
    localparam int LATENCY     = 43;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1400;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count, pending_count, result_count, degenerate_count;
    int           idle_cycles;
    bit           quiet_phase;
    bit           long_hold;
    bit           bits_hi[128];
    bit           bits_lo[128];

    quaternion_multiply_normalize dut (.*);

    quaternion_product_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        int burst;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic [127:0] d, bit allow_gap);
        int gap;
        if (allow_gap && !quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        for (int b = 0; b < 128; b++) begin
            if (d[b]) bits_hi[b] = 1; else bits_lo[b] = 1;
        end
    endtask

    function automatic logic [127:0] pack_q(logic [15:0] a, b, c, e, f, g, h, k);
        return {k, h, g, f, e, c, b, a};
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 32)) - 16);
            3: return 16'h4000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] rand_item();
        logic [127:0] d;
        for (int i = 0; i < 8; i++) d[16*i +: 16] = rand_comp();
        // sometimes unit and near-unit w components in the operand pair
        if ($urandom_range(0, 3) == 0) begin
            d[15:0]  = 16'h4000;
            d[79:64] = 16'(16384 - $urandom_range(0, 64));
        end
        return d;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    initial begin
        quiet_phase = 1'b0;
        long_hold = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners: zeros, identity, extremes, tiny products that round to zero
        send_item('0, 1'b0);
        send_item(pack_q(16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000), 1'b0);
        send_item({8{16'h8000}}, 1'b0);
        send_item({8{16'h7fff}}, 1'b0);
        send_item({4{16'h7fff, 16'h8000}}, 1'b0);
        send_item(pack_q(16'd1, 16'h0, 16'h0, 16'h0, 16'd1, 16'h0, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'd90, 16'h0, 16'h0, 16'h0, 16'd91, 16'h0, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'd128, 16'h0, 16'h0, 16'h0, 16'd64, 16'h0, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         16'd1, 16'd1, 16'd1, 16'd1), 1'b0);
        send_item(pack_q(16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0), 1'b0);
        send_item(pack_q(16'h2d41, 16'h2d41, 16'h0, 16'h0,
                         16'h2d41, 16'h0, 16'h2d41, 16'h0), 1'b0);
        send_item(pack_q(16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h7fff), 1'b0);
        send_item(pack_q(16'd1, 16'd0, 16'd0, 16'd0, 16'h4000, 16'h0, 16'h0, 16'h0), 1'b0);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) long_hold = 1'b1;
            if (n == 700) drain();
            if (n == RANDOM_ITEMS - 150) quiet_phase = 1'b1;
            send_item(rand_item(), 1'b1);
        end
        drain();

        for (int b = 0; b < 128; b++)
            if (!bits_hi[b] || !bits_lo[b]) $display("input bit %0d did not toggle", b);
        $display("%0d results checked, %0d of them degenerate, with random stalls on both sides",
                 result_count, degenerate_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
